// ===== hdl/kmp_pkg.sv =====
// ============================================================================
// kmp_pkg: shared types and constants of the pattern matcher
// Sizes of the pattern store and the position counter, register index codes
// and the control bundle that drives the row of match cells.
// ============================================================================
package kmp_pkg;

    // Longest pattern the cell row can hold (1 to 32).
    localparam int PATTERN_MAX   = 32;
    // Width of the text position counter (16 to 64).
    localparam int POSITION_BITS = 32;

    localparam int BYTE_BITS     = 8;
    localparam int WORD_BITS     = 64;
    localparam int PATTERN_WORDS = 4;
    localparam int WORD_BYTES    = WORD_BITS / BYTE_BITS;
    localparam int LENGTH_BITS   = 6;
    localparam int INDEX_BITS    = 3;
    localparam int MATCH_BITS    = 32;

    // Effective length (1 to PATTERN_MAX) and a cell index.
    localparam int PLEN_BITS     = $clog2(PATTERN_MAX + 1);
    localparam int CELL_BITS     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    // Width in which a match start is formed before clamping to 32 bits.
    localparam int START_BITS    = (POSITION_BITS > MATCH_BITS) ? POSITION_BITS
                                                                : MATCH_BITS;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } cfg_reg_t;

    typedef logic [PATTERN_MAX-1:0][BYTE_BITS-1:0] pattern_t;

    // advance: a text byte is transferred; flush: all partial matches drop.
    typedef struct packed {
        logic advance;
        logic flush;
    } cell_ctrl_t;

endpackage

// ===== hdl/kmp_pattern_matcher.sv =====
// ============================================================================
// kmp_pattern_matcher: exact byte-pattern search over a text stream
// Reports the start position of every occurrence of a configured pattern of
// up to 32 bytes, overlapping occurrences included.
// ============================================================================
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ----------------------------
//  text     in         text_valid/text_stall    text_byte, end_of_text
//  match    out        match_valid/match_stall  match_start
//  cfg      in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
//  One text byte is taken every cycle while text_stall is low. A match
//  completed by a byte appears in the output register in the cycle after
//  that byte's transfer: the cell row decides the match combinationally
//  in the cycle of the transfer, and only the output register follows.
//  Reset needs no clearing pass: the row and the counter clear at once, and
//  the pattern comes up as one zero byte. text_stall is high only while a
//  result waits in the output register and match_stall holds it there.
//
// The search is the shift form of the failure-table matcher: cell k holds
// whether the text read so far ends in the first k+1 pattern bytes. Each
// transfer moves every flag one cell on, kept only where the cell's pattern
// byte equals the new text byte, so the row tracks every live partial match
// at once and reports exactly the occurrences the fallback scheme finds.
// The cell at the current pattern length signals a full match. An end of
// text, or a write to a known register, clears the row and the position.
// ============================================================================
module kmp_pattern_matcher
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 text_valid,
    output logic                                 text_stall,
    input  logic [7:0]                           text_byte,
    input  logic                                 end_of_text,
    output logic                                 match_valid,
    input  logic                                 match_stall,
    output logic [31:0]                          match_start,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kmp_pkg::INDEX_BITS-1:0]       cfg_index,
    input  logic [kmp_pkg::WORD_BITS-1:0]        cfg_data
);

    localparam logic [kmp_pkg::POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [kmp_pkg::START_BITS-1:0] START_LIMIT =
        kmp_pkg::START_BITS'({kmp_pkg::MATCH_BITS{1'b1}});

    logic                                reload;
    logic [kmp_pkg::PLEN_BITS-1:0]       plen;
    kmp_pkg::pattern_t                   pattern;
    kmp_pkg::cell_ctrl_t                 ctrl;
    logic                                text_accept;
    logic [kmp_pkg::PATTERN_MAX-1:0]     hit;
    logic [kmp_pkg::PATTERN_MAX-1:0]     flag;
    logic [kmp_pkg::CELL_BITS-1:0]       last_cell;
    logic                                full_match;

    logic [kmp_pkg::POSITION_BITS-1:0]   pos_reg;
    logic [kmp_pkg::POSITION_BITS-1:0]   pos_next;
    logic [kmp_pkg::POSITION_BITS-1:0]   pos_inc;
    logic [kmp_pkg::START_BITS-1:0]      start_wide;
    logic                                match_valid_reg;
    logic                                match_valid_next;
    logic [31:0]                         match_start_reg;
    logic [31:0]                         match_start_next;

    // The configuration registers take every write in the cycle it is offered.
    assign cfg_ready = 1'b1;

    kmp_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .reload    (reload),
        .plen      (plen),
        .pattern   (pattern)
    );

    // A byte may enter unless a result is held back by the consumer, since
    // the byte might complete another match.
    assign text_stall  = match_valid_reg && match_stall;
    assign text_accept = text_valid && !text_stall;

    // The end-of-text byte is still matched; the flush wins in the flags only.
    // The bundle is advance followed by flush.
    assign ctrl = {text_accept, reload || (text_accept && end_of_text)};

    for (genvar k = 0; k < kmp_pkg::PATTERN_MAX; k++)
    begin : g_cell
        logic prev_flag;
        if (k == 0)
        begin : g_first
            // The empty prefix always matches.
            assign prev_flag = 1'b1;
        end
        else
        begin : g_rest
            assign prev_flag = flag[k-1];
        end

        kmp_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .pat_byte  (pattern[k]),
            .text_byte (text_byte),
            .prev_flag (prev_flag),
            .hit       (hit[k]),
            .flag      (flag[k])
        );
    end

    assign last_cell  = kmp_pkg::CELL_BITS'(plen - kmp_pkg::PLEN_BITS'(1));
    assign full_match = hit[last_cell];

    // Position after this byte, saturating at the counter's maximum; the
    // match began that many bytes back, less the pattern length.
    assign pos_inc    = (pos_reg == POS_MAX) ? pos_reg
                                             : pos_reg + kmp_pkg::POSITION_BITS'(1);
    assign start_wide = kmp_pkg::START_BITS'(pos_inc) - kmp_pkg::START_BITS'(plen);

    always_comb
    begin
        pos_next = pos_reg;
        if (reload)
        begin
            pos_next = '0;
        end
        else if (text_accept)
        begin
            pos_next = end_of_text ? '0 : pos_inc;
        end
    end

    always_comb
    begin
        match_valid_next = match_valid_reg;
        match_start_next = match_start_reg;
        if (text_accept && full_match)
        begin
            match_valid_next = 1'b1;
            match_start_next = (start_wide > START_LIMIT) ? '1 : start_wide[31:0];
        end
        else if (!match_stall)
        begin
            match_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            match_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            match_valid_reg <= match_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_start_reg <= match_start_next;
    end

    assign match_valid = match_valid_reg;
    assign match_start = match_start_reg;

    // A known register write starts the search afresh.
    a_reload_clears: assert property (@(posedge clk) disable iff (!rst_n)
        reload |=> (pos_reg == '0) && (flag == '0))
        else $error("position or cell row not cleared after a register write");

    // The last byte of a text leaves no partial match behind.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (text_accept && end_of_text && !reload) |=> (pos_reg == '0) && (flag == '0))
        else $error("state not cleared after end of text");

    // A new result only follows a byte transfer that completed a match.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(match_valid) |-> $past(text_accept && full_match))
        else $error("result appeared without a completing byte");

    // Text is only held back by a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        text_stall |-> (match_valid && match_stall))
        else $error("text stalled without a waiting result");

endmodule

// ===== hdl/kmp_cfg_regs.sv =====
// ============================================================================
// kmp_cfg_regs: configuration registers of the pattern matcher
// Holds the packed pattern words and the clamped pattern length, and flags
// every write to a known register so that matching restarts.
// ============================================================================
module kmp_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [kmp_pkg::INDEX_BITS-1:0]        cfg_index,
    input  logic [kmp_pkg::WORD_BITS-1:0]         cfg_data,
    output logic                                  reload,
    output logic [kmp_pkg::PLEN_BITS-1:0]         plen,
    output kmp_pkg::pattern_t                     pattern
);

    logic [kmp_pkg::PLEN_BITS-1:0] plen_reg;
    logic [kmp_pkg::PLEN_BITS-1:0] plen_next;
    logic [kmp_pkg::PATTERN_WORDS-1:0][kmp_pkg::WORD_BITS-1:0] word_reg;
    logic [kmp_pkg::PATTERN_WORDS-1:0][kmp_pkg::WORD_BITS-1:0] word_next;
    logic [kmp_pkg::LENGTH_BITS-1:0] length_raw;

    assign length_raw = cfg_data[kmp_pkg::LENGTH_BITS-1:0];

    always_comb
    begin
        plen_next = plen_reg;
        word_next = word_reg;
        reload    = 1'b0;
        if (cfg_valid)
        begin
            case (kmp_pkg::cfg_reg_t'(cfg_index))
                kmp_pkg::REG_PATTERN_LENGTH:
                begin
                    reload = 1'b1;
                    // A zero length acts as one, an overlong one as the maximum.
                    if (length_raw == '0)
                    begin
                        plen_next = kmp_pkg::PLEN_BITS'(1);
                    end
                    else if (length_raw > kmp_pkg::LENGTH_BITS'(kmp_pkg::PATTERN_MAX))
                    begin
                        plen_next = kmp_pkg::PLEN_BITS'(kmp_pkg::PATTERN_MAX);
                    end
                    else
                    begin
                        plen_next = kmp_pkg::PLEN_BITS'(length_raw);
                    end
                end
                kmp_pkg::REG_PATTERN_WORD_0:
                begin
                    reload       = 1'b1;
                    word_next[0] = cfg_data;
                end
                kmp_pkg::REG_PATTERN_WORD_1:
                begin
                    reload       = 1'b1;
                    word_next[1] = cfg_data;
                end
                kmp_pkg::REG_PATTERN_WORD_2:
                begin
                    reload       = 1'b1;
                    word_next[2] = cfg_data;
                end
                kmp_pkg::REG_PATTERN_WORD_3:
                begin
                    reload       = 1'b1;
                    word_next[3] = cfg_data;
                end
                default:
                begin
                    reload = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= kmp_pkg::PLEN_BITS'(1);
            word_reg <= '0;
        end
        else
        begin
            plen_reg <= plen_next;
            word_reg <= word_next;
        end
    end

    assign plen = plen_reg;

    for (genvar k = 0; k < kmp_pkg::PATTERN_MAX; k++)
    begin : g_byte
        assign pattern[k] = word_reg[k / kmp_pkg::WORD_BYTES]
                                    [(k % kmp_pkg::WORD_BYTES) * kmp_pkg::BYTE_BITS +:
                                     kmp_pkg::BYTE_BITS];
    end

endmodule

// ===== hdl/kmp_cell.sv =====
// ============================================================================
// kmp_cell: one position of the match row
// Remembers whether the text so far ends in the pattern prefix that finishes
// at this cell's byte, and hands that flag on to the next cell.
// ============================================================================
module kmp_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  kmp_pkg::cell_ctrl_t                ctrl,
    input  logic [kmp_pkg::BYTE_BITS-1:0]      pat_byte,
    input  logic [kmp_pkg::BYTE_BITS-1:0]      text_byte,
    input  logic                               prev_flag,
    output logic                               hit,
    output logic                               flag
);

    logic flag_reg;
    logic flag_next;

    // The prefix one shorter held in the neighbour, extended by this byte.
    assign hit = prev_flag && (pat_byte == text_byte);

    always_comb
    begin
        flag_next = flag_reg;
        if (ctrl.flush)
        begin
            flag_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            flag_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    assign flag = flag_reg;

endmodule
